@@ rtl/core/bfra_pkg.sv @@
package bfra_pkg;

  // table geometry
  localparam int FREE_SLOTS = 16;
  localparam int IDX_W      = $clog2(FREE_SLOTS);
  localparam int SCAN_W     = $clog2(FREE_SLOTS + 1);

  // field widths
  localparam int CNT_W  = 21;
  localparam int BASE_W = 20;
  localparam int AGE_W  = 32;
  localparam int STAT_W = 3;

  // hard ceiling on heap size
  localparam logic [CNT_W-1:0] HEAP_LIMIT = CNT_W'(1048576);

  // request kinds
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // result codes
  typedef enum logic [STAT_W-1:0] {
    ST_REUSE     = 3'd0,
    ST_BUMP      = 3'd1,
    ST_BUMP_GROW = 3'd2,
    ST_NO_CAP    = 3'd3,
    ST_FREE_OK   = 3'd4,
    ST_FREE_FULL = 3'd5
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PICK,
    S_DONE
  } state_t;

  // one free table entry
  typedef struct packed {
    logic [CNT_W-1:0]  len;
    logic [BASE_W-1:0] base;
    logic [AGE_W-1:0]  age;
  } tbl_ent_t;

  // table access requests
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    tbl_ent_t         wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             clr_en;
    logic [IDX_W-1:0] clr_addr;
  } tbl_ctl_t;

  // table occupancy
  typedef struct packed {
    logic [IDX_W-1:0] free_idx;
    logic             full;
  } tbl_stat_t;

endpackage

@@ rtl/core/bfra_free_table.sv @@
module bfra_free_table (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bfra_pkg::tbl_ctl_t   ctl,
  output bfra_pkg::tbl_ent_t   rd_ent,
  output logic                 rd_used,
  output bfra_pkg::tbl_stat_t  stat
);

  bfra_pkg::tbl_ent_t mem [bfra_pkg::FREE_SLOTS];
  bfra_pkg::tbl_ent_t rd_ent_r;
  logic               rd_used_r;
  logic [bfra_pkg::FREE_SLOTS-1:0] used_r;

  // entry storage, one write and one registered read port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rd_ent_r <= mem[ctl.rd_addr];
    end
  end

  // occupancy bits, read in step with the entry data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= '0;
      rd_used_r <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        used_r[ctl.wr_addr] <= 1'b1;
      end
      if (ctl.clr_en) begin
        used_r[ctl.clr_addr] <= 1'b0;
      end
      if (ctl.rd_en) begin
        rd_used_r <= used_r[ctl.rd_addr];
      end
    end
  end

  // lowest unused entry
  always_comb begin
    stat.full     = 1'b1;
    stat.free_idx = '0;
    for (int i = bfra_pkg::FREE_SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        stat.full     = 1'b0;
        stat.free_idx = bfra_pkg::IDX_W'(i);
      end
    end
  end

  assign rd_ent  = rd_ent_r;
  assign rd_used = rd_used_r;

endmodule

@@ rtl/core/best_fit_range_allocator.sv @@
// channel  | handshake             | payload
// ---------+-----------------------+------------------------------------------------
// in       | in_valid / in_ready   | in_req_type, in_slot_count, in_free_start
// out      | out_valid / out_ready | out_status, out_grant_start, out_grant_size,
//          |                       | out_heap_slots
// cfg      | cfg_we                | cfg_wdata (max_capacity)
//
// a free beat goes from accept to the done state, which loads the result register;
// an allocate goes through the scan, pick and done states, the best-fit scan
// reading one table entry a cycle through the table's single read port. one item
// is in flight at a time. rst_n is synchronous, active low, and empties the table
// and heap. a stalled out beat holds the sequencer until the result register
// frees up.
module best_fit_range_allocator (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_req_type,
  input  logic [bfra_pkg::CNT_W-1:0]   in_slot_count,
  input  logic [bfra_pkg::BASE_W-1:0]  in_free_start,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bfra_pkg::STAT_W-1:0]  out_status,
  output logic [bfra_pkg::BASE_W-1:0]  out_grant_start,
  output logic [bfra_pkg::CNT_W-1:0]   out_grant_size,
  output logic [bfra_pkg::CNT_W-1:0]   out_heap_slots,
  input  logic                         cfg_we,
  input  logic [bfra_pkg::CNT_W-1:0]   cfg_wdata
);

  localparam int CNT_W  = bfra_pkg::CNT_W;
  localparam int BASE_W = bfra_pkg::BASE_W;
  localparam int AGE_W  = bfra_pkg::AGE_W;
  localparam int IDX_W  = bfra_pkg::IDX_W;
  localparam int SCAN_W = bfra_pkg::SCAN_W;

  bfra_pkg::state_t    state_r, state_nxt;
  bfra_pkg::tbl_ctl_t  tbl_ctl;
  bfra_pkg::tbl_ent_t  rd_ent;
  logic                rd_used;
  bfra_pkg::tbl_stat_t tbl_stat;

  // control state
  logic [CNT_W-1:0]  max_cap_r;
  logic [AGE_W-1:0]  age_cnt_r, age_cnt_nxt;
  logic [CNT_W-1:0]  heap_top_r, heap_top_nxt;
  logic [CNT_W-1:0]  heap_size_r, heap_size_nxt;
  logic [SCAN_W-1:0] scan_cnt_r, scan_cnt_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic              best_found_r, best_found_nxt;
  logic              out_valid_r, out_valid_nxt;

  // payload state
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic [CNT_W-1:0]  best_len_r, best_len_nxt;
  logic [BASE_W-1:0] best_base_r, best_base_nxt;
  logic [AGE_W-1:0]  best_dist_r, best_dist_nxt;
  bfra_pkg::status_t res_stat_r, res_stat_nxt;
  logic [BASE_W-1:0] res_start_r, res_start_nxt;
  logic [CNT_W-1:0]  res_size_r, res_size_nxt;
  bfra_pkg::status_t out_stat_r, out_stat_nxt;
  logic [BASE_W-1:0] out_start_r, out_start_nxt;
  logic [CNT_W-1:0]  out_size_r, out_size_nxt;
  logic [CNT_W-1:0]  out_heap_r, out_heap_nxt;

  // scan compare and bump arithmetic
  logic [AGE_W-1:0]  age_gap;
  logic              better;
  logic [CNT_W:0]    need;
  logic [CNT_W-1:0]  cap;
  logic [CNT_W+1:0]  dbl;
  logic [CNT_W+1:0]  grown;

  bfra_free_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (tbl_ctl),
    .rd_ent  (rd_ent),
    .rd_used (rd_used),
    .stat    (tbl_stat)
  );

  // best-fit test on the entry returned by the memory
  always_comb begin
    age_gap = age_cnt_r - rd_ent.age;
    better  = cmp_vld_r && rd_used && (rd_ent.len >= count_r) &&
              (!best_found_r || (rd_ent.len < best_len_r) ||
               ((rd_ent.len == best_len_r) && (age_gap > best_dist_r)));
  end

  // bump sizing
  always_comb begin
    need  = {1'b0, heap_top_r} + {1'b0, count_r};
    cap   = (max_cap_r < bfra_pkg::HEAP_LIMIT) ? max_cap_r : bfra_pkg::HEAP_LIMIT;
    dbl   = ({2'b00, heap_size_r} + (CNT_W+2)'(1)) << 1;
    grown = ({1'b0, need} > dbl) ? {1'b0, need} : dbl;
    if (grown > {2'b00, cap}) begin
      grown = {2'b00, cap};
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    age_cnt_nxt    = age_cnt_r;
    heap_top_nxt   = heap_top_r;
    heap_size_nxt  = heap_size_r;
    scan_cnt_nxt   = scan_cnt_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    best_found_nxt = best_found_r;
    count_nxt      = count_r;
    best_idx_nxt   = best_idx_r;
    best_len_nxt   = best_len_r;
    best_base_nxt  = best_base_r;
    best_dist_nxt  = best_dist_r;
    res_stat_nxt   = res_stat_r;
    res_start_nxt  = res_start_r;
    res_size_nxt   = res_size_r;
    out_valid_nxt  = out_valid_r;
    out_stat_nxt   = out_stat_r;
    out_start_nxt  = out_start_r;
    out_size_nxt   = out_size_r;
    out_heap_nxt   = out_heap_r;
    in_ready       = 1'b0;
    tbl_ctl        = '0;

    // result register drains independently
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // running best from the previous read
    if (better) begin
      best_found_nxt = 1'b1;
      best_idx_nxt   = cmp_idx_r;
      best_len_nxt   = rd_ent.len;
      best_base_nxt  = rd_ent.base;
      best_dist_nxt  = age_gap;
    end

    case (state_r)
      bfra_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          count_nxt = in_slot_count;
          if (in_req_type == bfra_pkg::REQ_FREE) begin
            // store the returned range in the lowest unused entry
            res_start_nxt = '0;
            res_size_nxt  = '0;
            if (tbl_stat.full) begin
              res_stat_nxt = bfra_pkg::ST_FREE_FULL;
            end else begin
              res_stat_nxt         = bfra_pkg::ST_FREE_OK;
              tbl_ctl.wr_en        = 1'b1;
              tbl_ctl.wr_addr      = tbl_stat.free_idx;
              tbl_ctl.wr_data.len  = in_slot_count;
              tbl_ctl.wr_data.base = in_free_start;
              tbl_ctl.wr_data.age  = age_cnt_r;
              age_cnt_nxt          = age_cnt_r + AGE_W'(1);
            end
            state_nxt = bfra_pkg::S_DONE;
          end else begin
            scan_cnt_nxt   = '0;
            best_found_nxt = 1'b0;
            state_nxt      = bfra_pkg::S_SCAN;
          end
        end
      end

      bfra_pkg::S_SCAN: begin
        // one read a cycle; the last compare lands when the count reaches the depth
        if (scan_cnt_r == SCAN_W'(bfra_pkg::FREE_SLOTS)) begin
          state_nxt = bfra_pkg::S_PICK;
        end else begin
          tbl_ctl.rd_en   = 1'b1;
          tbl_ctl.rd_addr = scan_cnt_r[IDX_W-1:0];
          cmp_vld_nxt     = 1'b1;
          cmp_idx_nxt     = scan_cnt_r[IDX_W-1:0];
          scan_cnt_nxt    = scan_cnt_r + SCAN_W'(1);
        end
      end

      bfra_pkg::S_PICK: begin
        if (best_found_r) begin
          // reuse the whole freed range
          tbl_ctl.clr_en   = 1'b1;
          tbl_ctl.clr_addr = best_idx_r;
          res_stat_nxt     = bfra_pkg::ST_REUSE;
          res_start_nxt    = best_base_r;
          res_size_nxt     = best_len_r;
        end else if (need > {1'b0, heap_size_r}) begin
          if (need > {1'b0, cap}) begin
            res_stat_nxt  = bfra_pkg::ST_NO_CAP;
            res_start_nxt = '0;
            res_size_nxt  = '0;
          end else begin
            res_stat_nxt  = bfra_pkg::ST_BUMP_GROW;
            res_start_nxt = heap_top_r[BASE_W-1:0];
            res_size_nxt  = count_r;
            heap_size_nxt = grown[CNT_W-1:0];
            heap_top_nxt  = need[CNT_W-1:0];
          end
        end else begin
          res_stat_nxt  = bfra_pkg::ST_BUMP;
          res_start_nxt = heap_top_r[BASE_W-1:0];
          res_size_nxt  = count_r;
          heap_top_nxt  = need[CNT_W-1:0];
        end
        state_nxt = bfra_pkg::S_DONE;
      end

      bfra_pkg::S_DONE: begin
        // hand the result over once the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = res_stat_r;
          out_start_nxt = res_start_r;
          out_size_nxt  = res_size_r;
          out_heap_nxt  = heap_size_r;
          state_nxt     = bfra_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = bfra_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bfra_pkg::S_IDLE;
      max_cap_r    <= bfra_pkg::HEAP_LIMIT;
      age_cnt_r    <= '0;
      heap_top_r   <= '0;
      heap_size_r  <= '0;
      scan_cnt_r   <= '0;
      cmp_vld_r    <= 1'b0;
      best_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      age_cnt_r    <= age_cnt_nxt;
      heap_top_r   <= heap_top_nxt;
      heap_size_r  <= heap_size_nxt;
      scan_cnt_r   <= scan_cnt_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      best_found_r <= best_found_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        max_cap_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmp_idx_r   <= cmp_idx_nxt;
    count_r     <= count_nxt;
    best_idx_r  <= best_idx_nxt;
    best_len_r  <= best_len_nxt;
    best_base_r <= best_base_nxt;
    best_dist_r <= best_dist_nxt;
    res_stat_r  <= res_stat_nxt;
    res_start_r <= res_start_nxt;
    res_size_r  <= res_size_nxt;
    out_stat_r  <= out_stat_nxt;
    out_start_r <= out_start_nxt;
    out_size_r  <= out_size_nxt;
    out_heap_r  <= out_heap_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_stat_r;
  assign out_grant_start = out_start_r;
  assign out_grant_size  = out_size_r;
  assign out_heap_slots  = out_heap_r;

endmodule
